// ===== hdl/mciir_pkg.sv =====
// Shared types, codes and sizing helpers for the multichannel IIR filter.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package mciir_pkg;

  // Field widths of the request and result items
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned COEF_W    = 18;
  localparam int unsigned CHAN_W    = 5;
  localparam int unsigned CIDX_W    = 6;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned PROD_W    = SAMPLE_W + COEF_W;

  // Configuration register widths and port layout
  localparam int unsigned FF_TAPS_W = 7;
  localparam int unsigned FB_TAPS_W = 5;
  localparam int unsigned NUM_CH_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 7;

  // Default sizes
  localparam int unsigned DEF_MAX_FF_TAPS  = 64;
  localparam int unsigned DEF_MAX_FB_TAPS  = 16;
  localparam int unsigned DEF_MAX_CHANNELS = 32;

  // Request commands
  localparam logic [CMD_W-1:0] CMD_FILTER = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_FF  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WR_FB  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FF_TAPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FB_TAPS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CH  = 2'd2;

  // Rounding offset for the Q.30 to Q1.15 step
  localparam int unsigned ROUND_HALF = 16384;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;    // start a new sum
    logic valid;    // operands present this cycle
    logic use_tap;  // tap is within the configured count
  } mac_ctrl_t;

  // Address width for a store of the given depth, at least one bit
  function automatic int unsigned addr_w(input int unsigned depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ===== hdl/mciir_in_if.sv =====
// Request channel of the multichannel IIR filter: valid/ready plus payload.
// Depends on mciir_pkg.
`timescale 1ns / 1ps

interface mciir_in_if;
  import mciir_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    command;
  logic [CHAN_W-1:0]   channel;
  sample_t             sample_in;
  logic [CIDX_W-1:0]   coef_index;
  coef_t               coef_value;

  modport source (
    output valid, command, channel, sample_in, coef_index, coef_value,
    input  ready
  );

  modport sink (
    input  valid, command, channel, sample_in, coef_index, coef_value,
    output ready
  );

endinterface

// ===== hdl/mciir_out_if.sv =====
// Result channel of the multichannel IIR filter: valid/ready plus payload.
// Depends on mciir_pkg.
`timescale 1ns / 1ps

interface mciir_out_if;
  import mciir_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_channel;
  sample_t           sample_out;
  logic              clipped;

  modport source (
    output valid, out_channel, sample_out, clipped,
    input  ready
  );

  modport sink (
    input  valid, out_channel, sample_out, clipped,
    output ready
  );

endinterface

// ===== hdl/mciir_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on mciir_pkg for the address width helper.
`timescale 1ns / 1ps

module mciir_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [mciir_pkg::addr_w(DEPTH)-1:0]      waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [mciir_pkg::addr_w(DEPTH)-1:0]      raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);
  import mciir_pkg::*;

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hdl/mciir_mac.sv =====
// Shared multiply-accumulate unit with Q.30 to Q1.15 rounding and saturation.
// Depends on mciir_pkg.
`timescale 1ns / 1ps

module mciir_mac #(
  parameter int unsigned ACC_W = 40
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mciir_pkg::mac_ctrl_t ctrl_i,
  input  mciir_pkg::sample_t   x_i,
  input  mciir_pkg::coef_t     coef_i,
  output mciir_pkg::sample_t   y_o,
  output logic                 clip_o
);
  import mciir_pkg::*;

  localparam int unsigned Q_W = ACC_W + 1 - 15;

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_valid_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [ACC_W:0]    rnd;
  logic signed [Q_W-1:0]    quo;
  logic                     ovf;

  // Signed product of sample and coefficient
  assign prod = x_i * coef_i;

  // Multiply stage: drop taps beyond the configured count
  always_ff @(posedge clk_i) begin
    prod_q <= ctrl_i.use_tap ? prod : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= ctrl_i.valid;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_valid_q) begin
      acc_q <= acc_q + {{(ACC_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
    end
  end

  // Round half up, floor shift, then saturate to 16 bits
  assign rnd = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(ROUND_HALF);
  assign quo = rnd[ACC_W:15];
  assign ovf = (quo[Q_W-1:SAMPLE_W-1] != {(Q_W-SAMPLE_W+1){1'b0}})
            && (quo[Q_W-1:SAMPLE_W-1] != {(Q_W-SAMPLE_W+1){1'b1}});

  always_comb begin
    clip_o = ovf;
    if (!ovf) begin
      y_o = quo[SAMPLE_W-1:0];
    end else if (quo[Q_W-1]) begin
      y_o = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      y_o = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

endmodule

// ===== hdl/multichannel_iir_filter_top.sv =====
// Channel       | Dir | Handshake           | Payload
// sample_req_i  | in  | valid/ready         | command, channel, sample_in, coef_index, coef_value
// result_o      | out | valid/ready         | out_channel, sample_out, clipped
// cfg_*         | in  | write enable only   | cfg_idx_i, cfg_data_i
//
// A filter request makes one shared multiplier walk every feed-forward then every
// feedback tap while the history RAMs shift in place; no new request is taken
// until its result is registered. Coefficient writes and dropped requests leave the
// sequencer idle. After reset a clearing pass of max((MAX_FF_TAPS-1), 1) or
// MAX_FB_TAPS times MAX_CHANNELS entries (2016 by default) runs before the first
// request. A stalled result holds the last step until the output register frees.
// Depends on mciir_pkg, mciir_in_if, mciir_out_if, mciir_ram and mciir_mac.
`timescale 1ns / 1ps

module multichannel_iir_filter_top #(
  parameter int unsigned MAX_FF_TAPS  = mciir_pkg::DEF_MAX_FF_TAPS,
  parameter int unsigned MAX_FB_TAPS  = mciir_pkg::DEF_MAX_FB_TAPS,
  parameter int unsigned MAX_CHANNELS = mciir_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mciir_in_if.sink                            sample_req_i,
  mciir_out_if.source                         result_o,
  input  logic                                cfg_we_i,
  input  logic [mciir_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mciir_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import mciir_pkg::*;

  // Storage sizing
  localparam int unsigned IH_PER_CH = MAX_FF_TAPS - 1;
  localparam int unsigned IH_DEPTH  = ((IH_PER_CH > 0) ? IH_PER_CH : 1) * MAX_CHANNELS;
  localparam int unsigned OH_DEPTH  = MAX_FB_TAPS * MAX_CHANNELS;
  localparam int unsigned CLR_DEPTH = (IH_DEPTH > OH_DEPTH) ? IH_DEPTH : OH_DEPTH;
  localparam int unsigned IH_AW     = addr_w(IH_DEPTH);
  localparam int unsigned OH_AW     = addr_w(OH_DEPTH);
  localparam int unsigned CLR_W     = addr_w(CLR_DEPTH);
  localparam int unsigned FF_AW     = addr_w(MAX_FF_TAPS);
  localparam int unsigned FB_AW     = addr_w(MAX_FB_TAPS);
  localparam int unsigned IDX_W     = (FF_AW > FB_AW) ? FF_AW : FB_AW;
  localparam int unsigned ACC_W     = PROD_W + $clog2(MAX_FF_TAPS + MAX_FB_TAPS);

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FF    = 3'd2;
  localparam logic [2:0] S_FB    = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [CLR_W-1:0]       clr_cnt_q;
  logic [IDX_W-1:0]       idx_q;
  logic                   drain_q;
  logic [FF_TAPS_W-1:0]   ff_taps_q;
  logic [FB_TAPS_W-1:0]   fb_taps_q;
  logic [NUM_CH_W-1:0]    num_ch_q;

  // Request payload held for the walk
  logic [CHAN_W-1:0]      ch_q;
  sample_t                x_q;
  logic [IH_AW-1:0]       ih_base_q;
  logic [OH_AW-1:0]       oh_base_q;

  // Read-data stage tags
  logic                   b_valid_q;
  logic                   b_fb_q;
  logic [IDX_W-1:0]       b_idx_q;

  // Result register
  logic                   out_valid_q;
  logic [CHAN_W-1:0]      out_ch_q;
  sample_t                out_y_q;
  logic                   out_clip_q;

  logic                   req_fire;
  logic                   req_filter;
  logic                   ch_ok;
  logic                   out_free;
  logic                   done_fire;

  // RAM ports
  logic                   ih_we, oh_we, ff_we, fb_we;
  logic [IH_AW-1:0]       ih_waddr, ih_raddr;
  logic [OH_AW-1:0]       oh_waddr, oh_raddr;
  sample_t                ih_wdata, oh_wdata, ih_rdata, oh_rdata;
  logic [FF_AW-1:0]       ff_raddr;
  logic [FB_AW-1:0]       fb_raddr;
  coef_t                  ff_rdata, fb_rdata;

  mac_ctrl_t              mac_ctrl;
  sample_t                mac_x;
  coef_t                  mac_coef;
  sample_t                mac_y;
  logic                   mac_clip;

  // Request decode
  assign sample_req_i.ready = (state_q == S_IDLE);
  assign req_fire   = sample_req_i.valid && sample_req_i.ready;
  assign ch_ok      = (32'(sample_req_i.channel) < 32'(num_ch_q))
                   && (32'(sample_req_i.channel) < MAX_CHANNELS);
  assign req_filter = req_fire && (sample_req_i.command == CMD_FILTER) && ch_ok;
  assign out_free   = !out_valid_q || result_o.ready;
  assign done_fire  = (state_q == S_DONE) && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (32'(clr_cnt_q) == CLR_DEPTH - 1) state_d = S_IDLE;
      S_IDLE:  if (req_filter) state_d = S_FF;
      S_FF:    if (idx_q == '0) state_d = S_FB;
      S_FB:    if (idx_q == '0) state_d = S_DRAIN;
      S_DRAIN: if (drain_q) state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_cnt_q <= '0;
      idx_q     <= '0;
      drain_q   <= 1'b0;
      b_valid_q <= 1'b0;
      b_fb_q    <= 1'b0;
      b_idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      // advance the tap index
      if (req_filter) begin
        idx_q <= IDX_W'(MAX_FF_TAPS - 1);
      end else if (state_q == S_FF && idx_q == '0) begin
        idx_q <= IDX_W'(MAX_FB_TAPS - 1);
      end else if (state_q == S_FF || state_q == S_FB) begin
        idx_q <= idx_q - 1'b1;
      end
      drain_q   <= (state_q == S_DRAIN) && !drain_q;
      b_valid_q <= (state_q == S_FF) || (state_q == S_FB);
      b_fb_q    <= (state_q == S_FB);
      b_idx_q   <= idx_q;
    end
  end

  // Latch the request payload
  always_ff @(posedge clk_i) begin
    if (req_filter) begin
      ch_q      <= sample_req_i.channel;
      x_q       <= sample_req_i.sample_in;
      ih_base_q <= IH_AW'(32'(sample_req_i.channel) * IH_PER_CH);
      oh_base_q <= OH_AW'(32'(sample_req_i.channel) * MAX_FB_TAPS);
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ff_taps_q <= FF_TAPS_W'(1);
      fb_taps_q <= '0;
      num_ch_q  <= NUM_CH_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FF_TAPS: ff_taps_q <= cfg_data_i[FF_TAPS_W-1:0];
        CFG_FB_TAPS: fb_taps_q <= cfg_data_i[FB_TAPS_W-1:0];
        CFG_NUM_CH:  num_ch_q  <= cfg_data_i[NUM_CH_W-1:0];
        default: ;
      endcase
    end
  end

  // Coefficient writes
  assign ff_we = req_fire && (sample_req_i.command == CMD_WR_FF)
              && (32'(sample_req_i.coef_index) < MAX_FF_TAPS);
  assign fb_we = req_fire && (sample_req_i.command == CMD_WR_FB)
              && (32'(sample_req_i.coef_index) < MAX_FB_TAPS);

  // Read addresses for the tap being issued
  assign ff_raddr = FF_AW'(idx_q);
  assign fb_raddr = FB_AW'(idx_q);
  assign ih_raddr = ih_base_q + IH_AW'(idx_q - 1'b1);
  assign oh_raddr = oh_base_q + OH_AW'(idx_q);

  // Input history: clear, or shift each entry one place older
  always_comb begin
    if (state_q == S_CLEAR) begin
      ih_we    = 32'(clr_cnt_q) < IH_DEPTH;
      ih_waddr = clr_cnt_q[IH_AW-1:0];
      ih_wdata = '0;
    end else begin
      ih_we    = b_valid_q && !b_fb_q && (32'(b_idx_q) < IH_PER_CH);
      ih_waddr = ih_base_q + IH_AW'(b_idx_q);
      ih_wdata = (b_idx_q == '0) ? x_q : ih_rdata;
    end
  end

  // Output history: clear, shift, then store the new output at the head
  always_comb begin
    if (state_q == S_CLEAR) begin
      oh_we    = 32'(clr_cnt_q) < OH_DEPTH;
      oh_waddr = clr_cnt_q[OH_AW-1:0];
      oh_wdata = '0;
    end else if (done_fire) begin
      oh_we    = 1'b1;
      oh_waddr = oh_base_q;
      oh_wdata = mac_y;
    end else begin
      oh_we    = b_valid_q && b_fb_q && (32'(b_idx_q) + 1 < MAX_FB_TAPS);
      oh_waddr = oh_base_q + OH_AW'(b_idx_q) + 1'b1;
      oh_wdata = oh_rdata;
    end
  end

  mciir_ram #(.WIDTH(COEF_W), .DEPTH(MAX_FF_TAPS)) u_ff_coef (
    .clk_i   (clk_i),
    .we_i    (ff_we),
    .waddr_i (FF_AW'(sample_req_i.coef_index)),
    .wdata_i (sample_req_i.coef_value),
    .raddr_i (ff_raddr),
    .rdata_o (ff_rdata)
  );

  mciir_ram #(.WIDTH(COEF_W), .DEPTH(MAX_FB_TAPS)) u_fb_coef (
    .clk_i   (clk_i),
    .we_i    (fb_we),
    .waddr_i (FB_AW'(sample_req_i.coef_index)),
    .wdata_i (sample_req_i.coef_value),
    .raddr_i (fb_raddr),
    .rdata_o (fb_rdata)
  );

  mciir_ram #(.WIDTH(SAMPLE_W), .DEPTH(IH_DEPTH)) u_in_hist (
    .clk_i   (clk_i),
    .we_i    (ih_we),
    .waddr_i (ih_waddr),
    .wdata_i (ih_wdata),
    .raddr_i (ih_raddr),
    .rdata_o (ih_rdata)
  );

  mciir_ram #(.WIDTH(SAMPLE_W), .DEPTH(OH_DEPTH)) u_out_hist (
    .clk_i   (clk_i),
    .we_i    (oh_we),
    .waddr_i (oh_waddr),
    .wdata_i (oh_wdata),
    .raddr_i (oh_raddr),
    .rdata_o (oh_rdata)
  );

  // Operand select for the shared multiplier
  always_comb begin
    mac_ctrl.clear = req_filter;
    mac_ctrl.valid = b_valid_q;
    if (b_fb_q) begin
      mac_x            = oh_rdata;
      mac_coef         = fb_rdata;
      mac_ctrl.use_tap = b_valid_q && (32'(b_idx_q) < 32'(fb_taps_q));
    end else begin
      mac_x            = (b_idx_q == '0) ? x_q : ih_rdata;
      mac_coef         = ff_rdata;
      mac_ctrl.use_tap = b_valid_q && (32'(b_idx_q) < 32'(ff_taps_q));
    end
  end

  mciir_mac #(.ACC_W(ACC_W)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .x_i    (mac_x),
    .coef_i (mac_coef),
    .y_o    (mac_y),
    .clip_o (mac_clip)
  );

  // Result register: load on completion, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_ch_q   <= ch_q;
      out_y_q    <= mac_y;
      out_clip_q <= mac_clip;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.out_channel = out_ch_q;
  assign result_o.sample_out  = out_y_q;
  assign result_o.clipped     = out_clip_q;

  // A new result appears only from the completion step
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside completion step");

  // Input history changes only while clearing or during the feed-forward walk
  a_ih_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ih_we && state_q != S_CLEAR) |-> (b_valid_q && !b_fb_q))
    else $error("stray input history write");

  // Output history writes stay within the current channel's block
  a_oh_write_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oh_we && state_q != S_CLEAR) |->
      (32'(oh_waddr) - 32'(oh_base_q) < MAX_FB_TAPS))
    else $error("output history write outside channel");

  // Tap pipeline is empty whenever a new request can be taken
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !b_valid_q)
    else $error("tap pipeline busy while idle");

endmodule
